// ===== src/sfcc_pkg.sv =====
// shared types, constants and crc helpers for the serial frame crc checker
`default_nettype none

package sfcc_pkg;

    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 6;
    localparam int PCT_W       = 7;
    localparam int SHOWN_WORDS = 4;
    localparam int PCT_DEPTH   = 1 << CNT_W;

    localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [WORD_W-1:0] CRC_TOP  = 32'h8000_0000;
    localparam logic [1:0]        LAST_LANE = 2'd3;
    localparam logic [PCT_W-1:0]  PCT_SCALE = 7'd100;

    typedef logic [WORD_W-1:0] t_crc_cols [WORD_W];
    typedef logic [PCT_W-1:0]  t_pct_tab  [PCT_DEPTH];

    typedef struct packed {
        logic done;
        logic crc_ok;
    } t_frame_info;

    typedef struct packed {
        logic             valid;
        logic [PCT_W-1:0] percent;
    } t_rate_info;

    // image of each single input bit after a full 32-bit crc pass
    function automatic t_crc_cols crc_columns();
        t_crc_cols   cols;
        logic [WORD_W-1:0] v;
        for (int i = 0; i < WORD_W; i++) begin
            v = WORD_W'(1) << i;
            for (int s = 0; s < WORD_W; s++) begin
                if ((v & CRC_TOP) != '0) begin
                    v = (v << 1) ^ CRC_POLY;
                end else begin
                    v = v << 1;
                end
            end
            cols[i] = v;
        end
        return cols;
    endfunction

    localparam t_crc_cols CRC_COLS = crc_columns();

    // crc is linear, so a word update is an xor of matrix columns
    function automatic logic [WORD_W-1:0] crc_word(
        input logic [WORD_W-1:0] crc,
        input logic [WORD_W-1:0] word
    );
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] r;
        x = crc ^ word;
        r = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (x[i]) begin
                r = r ^ CRC_COLS[i];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/serial_frame_crc_checker.sv =====
// top level: input register, frame assembly, statistics and result register
// a frame result enters the result register after its last byte has passed the input register
// throughput: one byte per cycle while the byte path is not held; the crc update and the counters are single-pass
// logic between the input register and the result register
// a full result register that is not being drained holds the byte path
// reset: synchronous active low; byte count, crc, counters and valids clear
`default_nettype none

module serial_frame_crc_checker
    import sfcc_pkg::*;
#(
    parameter int DATA_WORDS    = 4,
    parameter int WINDOW_FRAMES = 50
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [7:0]   i_s_tdata,   // rx_byte[7:0]
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [135:0]      o_m_tdata,   // data_word_0..3 [127:0], success_percent [134:128]
    output logic [1:0]        o_m_tuser    // crc_ok [0], rate_valid [1]
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic [SHOWN_WORDS-1:0][WORD_W-1:0] r_out_words;
    logic              r_out_ok;
    t_rate_info        r_out_rate;

    logic              out_free;
    logic              proc;
    logic              frame_fire;
    t_frame_info       frame;
    t_rate_info        rate;
    logic [SHOWN_WORDS-1:0][WORD_W-1:0] words;

    assign out_free   = !r_out_valid || i_m_tready;
    assign proc       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || proc;
    assign frame_fire = frame.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    sfcc_assembler #(
        .DATA_WORDS (DATA_WORDS)
    ) u_assembler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc),
        .i_byte  (r_in_byte),
        .o_frame (frame),
        .o_words (words)
    );

    sfcc_stats #(
        .WINDOW_FRAMES (WINDOW_FRAMES)
    ) u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (frame_fire),
        .i_crc_ok (frame.crc_ok),
        .o_rate   (rate)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (frame_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_fire) begin
            r_out_words <= words;
            r_out_ok    <= frame.crc_ok;
            r_out_rate  <= rate;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_rate.percent, r_out_words};
    assign o_m_tuser  = {r_out_rate.valid, r_out_ok};

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_fire |-> out_free)
        else $error("frame result produced while result register is full");

endmodule

`default_nettype wire

// ===== src/sfcc_assembler.sv =====
// byte counting, word assembly, frame word store and crc check
`default_nettype none

module sfcc_assembler
    import sfcc_pkg::*;
#(
    parameter int DATA_WORDS = 4
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_fire,
    input  wire logic [BYTE_W-1:0]                   i_byte,
    output t_frame_info                              o_frame,
    output logic [SHOWN_WORDS-1:0][WORD_W-1:0]       o_words
);

    localparam int FRAME_BYTES = (DATA_WORDS + 2) * 4;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int WIDX_W      = POS_W - 2;
    localparam logic [WIDX_W-1:0] CRC_WIDX  = WIDX_W'(DATA_WORDS);
    localparam logic [WIDX_W-1:0] LAST_WIDX = WIDX_W'(DATA_WORDS + 1);

    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [WORD_W-1:0] r_crc,   n_crc;
    logic [WORD_W-1:0] r_asm;
    logic              r_match, n_match;
    logic [WORD_W-1:0] r_words [DATA_WORDS];

    logic [1:0]        lane;
    logic [WIDX_W-1:0] widx;
    logic [WORD_W-1:0] word;
    logic              word_done;
    logic              data_done;

    assign lane = r_pos[1:0];
    assign widx = r_pos[POS_W-1:2];

    always_comb begin
        if (lane == 2'd0) begin
            word = WORD_W'(i_byte);
        end else begin
            word = r_asm | (WORD_W'(i_byte) << {lane, 3'b000});
        end
    end

    assign word_done = i_fire && (lane == LAST_LANE);
    assign data_done = word_done && (widx < CRC_WIDX);

    always_comb begin
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_match = r_match;
        o_frame.done   = 1'b0;
        o_frame.crc_ok = r_match;
        if (i_fire) begin
            n_pos = r_pos + POS_W'(1);
            if (lane == LAST_LANE) begin
                if (widx < CRC_WIDX) begin
                    n_crc = crc_word(r_crc, word);
                end else if (widx == CRC_WIDX) begin
                    n_match = (word == r_crc);
                end else if (widx == LAST_WIDX) begin
                    // unused word ends the frame
                    n_pos        = '0;
                    n_crc        = CRC_INIT;
                    o_frame.done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_crc   <= CRC_INIT;
            r_asm   <= '0;
            r_match <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_match <= n_match;
            if (i_fire) begin
                r_asm <= word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DATA_WORDS; k++) begin
            if (data_done && (widx == WIDX_W'(k))) begin
                r_words[k] <= word;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < SHOWN_WORDS; k++) begin
            if (k < DATA_WORDS) begin
                o_words[k] = r_words[k];
            end else begin
                o_words[k] = '0;
            end
        end
    end

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame.done |=> (r_pos == '0) && (r_crc == CRC_INIT))
        else $error("frame end did not restart byte count and crc");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(FRAME_BYTES - 1))
        else $error("byte position beyond frame length");

endmodule

`default_nettype wire

// ===== src/sfcc_stats.sv =====
// frame and error counters with window success percentage
`default_nettype none

module sfcc_stats
    import sfcc_pkg::*;
#(
    parameter int WINDOW_FRAMES = 50
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  wire logic i_crc_ok,
    output t_rate_info o_rate
);

    localparam logic [CNT_W-1:0] WINDOW = CNT_W'(WINDOW_FRAMES);

    // floor(100 * good / window) for every possible good count
    function automatic t_pct_tab pct_table();
        t_pct_tab tab;
        for (int g = 0; g < PCT_DEPTH; g++) begin
            tab[g] = PCT_W'((100 * g) / WINDOW_FRAMES);
        end
        return tab;
    endfunction

    localparam t_pct_tab PCT_TAB = pct_table();

    logic [CNT_W-1:0] r_frames, n_frames;
    logic [CNT_W-1:0] r_errors, n_errors;
    logic [CNT_W-1:0] frames_inc;
    logic [CNT_W-1:0] errors_inc;
    logic [CNT_W-1:0] good;
    logic             close;

    assign frames_inc = r_frames + CNT_W'(1);
    assign errors_inc = r_errors + CNT_W'(!i_crc_ok);
    assign close      = frames_inc >= WINDOW;
    assign good       = frames_inc - errors_inc;

    always_comb begin
        n_frames = r_frames;
        n_errors = r_errors;
        o_rate.valid   = close;
        o_rate.percent = close ? PCT_TAB[good] : '0;
        if (i_fire) begin
            if (close) begin
                n_frames = '0;
                n_errors = '0;
            end else begin
                n_frames = frames_inc;
                n_errors = errors_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= '0;
            r_errors <= '0;
        end else begin
            r_frames <= n_frames;
            r_errors <= n_errors;
        end
    end

    a_frames_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames < WINDOW)
        else $error("frame count reached window without clearing");

    a_errors_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_errors <= r_frames)
        else $error("error count exceeds frame count");

    a_percent_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rate.percent <= PCT_SCALE)
        else $error("success percentage above 100");

endmodule

`default_nettype wire
